@@ hdl/gmmps_pkg.sv @@
// Shared constants and types of the grid min/max path sum block.
`timescale 1ns / 1ps

package gmmps_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = 11;
    localparam int CELL_W   = 16;
    localparam int SUM_W    = 28;

    localparam logic [CNT_W-1:0] ROWS_TOP = CNT_W'(MAX_ROWS);
    localparam logic [CNT_W-1:0] COLS_TOP = CNT_W'(MAX_COLS);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // configuration register indexes
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    // position facts of one cell, decided when the cell is taken in
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             has_up;
        logic             has_left;
        logic             done;
        logic             even;
    } t_cell_pos;

endpackage

@@ hdl/gmmps_pos.sv @@
// Grid size registers and raster position counters.
`timescale 1ns / 1ps

module gmmps_pos (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [gmmps_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                      i_accept,
    output gmmps_pkg::t_cell_pos      o_pos
);
    import gmmps_pkg::*;

    logic [CNT_W-1:0] r_row_count;
    logic [CNT_W-1:0] r_col_count;
    logic [ROW_W-1:0] r_row_pos;
    logic [COL_W-1:0] r_col_pos;
    logic [ROW_W-1:0] n_row_pos;
    logic [COL_W-1:0] n_col_pos;
    logic [CNT_W-1:0] w_rows;
    logic [CNT_W-1:0] w_cols;
    logic             w_last_col;
    logic             w_last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CNT_W'(1);
            r_col_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                CFG_COL_COUNT: r_col_count <= i_cfg_data;
                default:       r_row_count <= r_row_count;
            endcase
        end
    end

    // zero counts as one, anything above MAX_ROWS or MAX_COLS as that maximum
    always_comb begin
        priority if (r_row_count == '0)     w_rows = CNT_W'(1);
        else if (r_row_count > ROWS_TOP)    w_rows = ROWS_TOP;
        else                                w_rows = r_row_count;
        priority if (r_col_count == '0)     w_cols = CNT_W'(1);
        else if (r_col_count > COLS_TOP)    w_cols = COLS_TOP;
        else                                w_cols = r_col_count;
    end

    assign w_last_col = (CNT_W'(r_col_pos) + CNT_W'(1)) >= w_cols;
    assign w_last_row = (CNT_W'(r_row_pos) + CNT_W'(1)) >= w_rows;

    always_comb begin
        if (w_last_col) begin
            n_col_pos = '0;
            n_row_pos = w_last_row ? '0 : r_row_pos + ROW_W'(1);
        end else begin
            n_col_pos = r_col_pos + COL_W'(1);
            n_row_pos = r_row_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (i_accept) begin
            r_row_pos <= n_row_pos;
            r_col_pos <= n_col_pos;
        end
    end

    assign o_pos.col      = r_col_pos;
    assign o_pos.has_up   = r_row_pos != '0;
    assign o_pos.has_left = r_col_pos != '0;
    assign o_pos.done     = w_last_col && w_last_row;
    // rows + cols - 1 is even exactly when rows and cols differ in parity
    assign o_pos.even     = w_rows[0] ^ w_cols[0];

endmodule

@@ hdl/gmmps_row_buf.sv @@
// One-row buffer of the upper neighbour's least and greatest sums.
`timescale 1ns / 1ps

module gmmps_row_buf (
    input  logic                                   i_clk,
    input  logic                                   i_rd_en,
    input  logic [gmmps_pkg::COL_W-1:0]            i_rd_addr,
    input  logic                                   i_wr_en,
    input  logic [gmmps_pkg::COL_W-1:0]            i_wr_addr,
    input  logic signed [gmmps_pkg::SUM_W-1:0]     i_wr_min,
    input  logic signed [gmmps_pkg::SUM_W-1:0]     i_wr_max,
    output logic signed [gmmps_pkg::SUM_W-1:0]     o_rd_min,
    output logic signed [gmmps_pkg::SUM_W-1:0]     o_rd_max
);
    import gmmps_pkg::*;

    logic [2*SUM_W-1:0] r_mem [MAX_COLS];
    logic [2*SUM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_max, i_wr_min};
        end
        // pass through a word written at the same edge to the same column
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= {i_wr_max, i_wr_min};
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_min = r_rd_data[SUM_W-1:0];
    assign o_rd_max = r_rd_data[2*SUM_W-1:SUM_W];

endmodule

@@ hdl/gmmps_core.sv @@
// Neighbour selection, saturating add and verdict for one cell.
`timescale 1ns / 1ps

module gmmps_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  gmmps_pkg::t_cell_pos                i_pos,
    input  logic signed [gmmps_pkg::CELL_W-1:0] i_cell,
    input  logic signed [gmmps_pkg::SUM_W-1:0]  i_up_min,
    input  logic signed [gmmps_pkg::SUM_W-1:0]  i_up_max,
    output logic signed [gmmps_pkg::SUM_W-1:0]  o_min,
    output logic signed [gmmps_pkg::SUM_W-1:0]  o_max,
    output logic                                o_zero_ok
);
    import gmmps_pkg::*;

    logic signed [SUM_W-1:0] r_left_min;
    logic signed [SUM_W-1:0] r_left_max;
    logic signed [SUM_W-1:0] w_lo;
    logic signed [SUM_W-1:0] w_hi;
    logic signed [SUM_W:0]   w_lo_sum;
    logic signed [SUM_W:0]   w_hi_sum;

    function automatic logic signed [SUM_W-1:0] sat(input logic signed [SUM_W:0] v);
        logic signed [SUM_W-1:0] r;
        begin
            if (v[SUM_W] != v[SUM_W-1]) begin
                r = v[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
                r = v[SUM_W-1:0];
            end
            return r;
        end
    endfunction

    always_comb begin
        priority if (i_pos.has_up && i_pos.has_left) begin
            w_lo = (i_up_min < r_left_min) ? i_up_min : r_left_min;
            w_hi = (i_up_max > r_left_max) ? i_up_max : r_left_max;
        end else if (i_pos.has_up) begin
            w_lo = i_up_min;
            w_hi = i_up_max;
        end else if (i_pos.has_left) begin
            w_lo = r_left_min;
            w_hi = r_left_max;
        end else begin
            w_lo = '0;
            w_hi = '0;
        end
    end

    assign w_lo_sum = (SUM_W+1)'(w_lo) + (SUM_W+1)'(i_cell);
    assign w_hi_sum = (SUM_W+1)'(w_hi) + (SUM_W+1)'(i_cell);
    assign o_min    = sat(w_lo_sum);
    assign o_max    = sat(w_hi_sum);

    assign o_zero_ok = i_pos.done && i_pos.even
                    && (o_min[SUM_W-1] || (o_min == '0)) && !o_max[SUM_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_min <= '0;
            r_left_max <= '0;
        end else if (i_adv) begin
            r_left_min <= o_min;
            r_left_max <= o_max;
        end
    end

endmodule

@@ hdl/grid_min_max_path_sum.sv @@
// Top level: least and greatest monotone path sums over a streamed grid.
// Cells enter in raster order, one word per clock while the output is not
// stalled, and each gives one result word: the input register also loads
// the upper neighbour's sums from a 1024-entry row memory, and the add,
// compare and saturation run between that register and the output register.
// The rate of one cell per cycle is set by the row memory's single read port
// and the left-neighbour add and compare. A result waiting at the output does
// not stop the next cell from entering an empty input register. tlast marks
// the bottom-right cell; the position counters then wrap for the next grid.
// The user must write row_count and col_count only while no cell is in
// flight; the block does not enforce it. The row memory needs no clearing,
// since every entry is written in the top row before a lower row reads it.
`timescale 1ns / 1ps

module grid_min_max_path_sum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] cell_value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [27:0] min_sum, [55:28] max_sum,
                                          // [56] zero_reachable, [63:57] zero
    output logic        o_m_axis_tlast    // grid_done
);
    import gmmps_pkg::*;

    logic                     w_accept;
    logic                     w_adv;
    t_cell_pos                w_pos;
    logic                     r_a_valid;
    t_cell_pos                r_a_pos;
    logic signed [CELL_W-1:0] r_a_cell;
    logic signed [SUM_W-1:0]  w_up_min;
    logic signed [SUM_W-1:0]  w_up_max;
    logic signed [SUM_W-1:0]  w_min;
    logic signed [SUM_W-1:0]  w_max;
    logic                     w_zero_ok;
    logic                     r_out_valid;
    logic signed [SUM_W-1:0]  r_out_min;
    logic signed [SUM_W-1:0]  r_out_max;
    logic                     r_out_done;
    logic                     r_out_zero;

    // advance the input register when the output register is free
    assign w_adv           = r_a_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_a_valid || w_adv;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    gmmps_pos u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .o_pos       (w_pos)
    );

    gmmps_row_buf u_row_buf (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_pos.col),
        .i_wr_en   (w_adv),
        .i_wr_addr (r_a_pos.col),
        .i_wr_min  (w_min),
        .i_wr_max  (w_max),
        .o_rd_min  (w_up_min),
        .o_rd_max  (w_up_max)
    );

    gmmps_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_pos     (r_a_pos),
        .i_cell    (r_a_cell),
        .i_up_min  (w_up_min),
        .i_up_max  (w_up_max),
        .o_min     (w_min),
        .o_max     (w_max),
        .o_zero_ok (w_zero_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_accept) begin
            r_a_valid <= 1'b1;
        end else if (w_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_pos  <= w_pos;
            r_a_cell <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_min  <= w_min;
            r_out_max  <= w_max;
            r_out_done <= r_a_pos.done;
            r_out_zero <= w_zero_ok;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_zero, r_out_max, r_out_min};
    assign o_m_axis_tlast  = r_out_done;

endmodule
